### sv/pbs_pkg.sv
`timescale 1ns / 1ps

package pbs_pkg;

  localparam int STACK_SLOTS_DEF = 64;
  localparam int REG_W   = 16;
  localparam int SLOT_W  = 64;
  localparam int SIDX_W  = $clog2(SLOT_W);

  localparam logic [3:0] FP_REG     = 4'd10;
  localparam logic [3:0] PSEUDO_SRC = 4'd1;
  // R0..R5: R0 is cleared by a helper call, R1..R5 must not stay marked
  localparam logic [REG_W-1:0] CALL_REGS = 16'h003f;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTSUPP = 2'd1,
    ST_FAULT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CLS_LD    = 3'd0,
    CLS_LDX   = 3'd1,
    CLS_ST    = 3'd2,
    CLS_STX   = 3'd3,
    CLS_ALU   = 3'd4,
    CLS_JMP   = 3'd5,
    CLS_JMP32 = 3'd6,
    CLS_ALU64 = 3'd7
  } cls_t;

  localparam logic [3:0] OP_CALL = 4'h8;
  localparam logic [3:0] OP_EXIT = 4'h9;
  localparam logic [3:0] OP_MOV  = 4'hb;

  localparam logic [2:0] MODE_ABS = 3'h1;
  localparam logic [2:0] MODE_IND = 3'h2;

  localparam logic ACT_LOAD = 1'b0;

endpackage

### sv/pbs_if.sv
`timescale 1ns / 1ps

interface pbs_in_if import pbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [7:0]              opcode;
  logic [3:0]              dest_reg;
  logic [3:0]              source_reg;
  logic signed [15:0]      offset;
  logic [REG_W-1:0]        load_regs;
  logic [SLOT_W-1:0]       load_slots;

  modport source (output valid, action, opcode, dest_reg, source_reg, offset,
                  load_regs, load_slots, input ready);
  modport sink   (input valid, action, opcode, dest_reg, source_reg, offset,
                  load_regs, load_slots, output ready);
endinterface

interface pbs_out_if import pbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [REG_W-1:0]        regs_out;
  logic [SLOT_W-1:0]       slots_out;
  logic                    all_clear;

  modport source (output valid, status, regs_out, slots_out, all_clear,
                  input ready);
  modport sink   (input valid, status, regs_out, slots_out, all_clear,
                  output ready);
endinterface

### sv/precision_backtrack_step.sv
`timescale 1ns / 1ps

// Backward precision tracking, one eBPF instruction per transfer.
// in_ch (sink): an item either loads the register/slot masks (action 0) or
//   steps one instruction backward (action 1). Feed instructions last to first.
// out_ch (source): one result per input item: status, both masks after the
//   item, and all_clear when both masks are zero.
// The masks and the result register update on the same edge that takes the
//   input transfer. One item per cycle is sustained while the receiver is
//   ready, set by the single mask feedback loop through the decode logic.
// When the receiver stalls, the result register holds; a new input transfer
//   is taken only in a cycle where the held result leaves (or none is held),
//   so at most one result waits.
// Reset (rst_n low, synchronous) clears both masks and drops the result valid.
// STACK_SLOTS bounds the frame slot number; slot accesses beyond it fault
//   and leave the slot mask unchanged.

module precision_backtrack_step import pbs_pkg::*; #(
  parameter int STACK_SLOTS = STACK_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pbs_in_if.sink    in_ch,
  pbs_out_if.source out_ch
);

  logic [REG_W-1:0]  reg_r, reg_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  status_t           status_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [REG_W-1:0]  out_regs_r;
  logic [SLOT_W-1:0] out_slots_r;
  logic              out_clear_r;

  logic              in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Instruction decode
  cls_t              cls;
  logic [3:0]        op;
  logic [2:0]        mode;
  logic              srcx;
  logic [REG_W-1:0]  dm, sm;

  assign cls  = cls_t'(in_ch.opcode[2:0]);
  assign op   = in_ch.opcode[7:4];
  assign mode = in_ch.opcode[7:5];
  assign srcx = in_ch.opcode[3];
  assign dm   = REG_W'(1) << in_ch.dest_reg;
  assign sm   = REG_W'(1) << in_ch.source_reg;

  // Frame slot: q = (-off-1)/8 truncated toward zero; -off-1 is ~off.
  // Negative values -7..-1 still land in slot zero.
  logic [15:0]       neg_off;
  logic              slot_ok;
  logic [SIDX_W-1:0] slot_idx;
  logic [SLOT_W-1:0] slot_bit;

  assign neg_off = ~in_ch.offset;

  always_comb begin
    if (neg_off[15]) begin
      slot_ok  = (&neg_off[15:3]) && (neg_off[2:0] != 3'd0);
      slot_idx = '0;
    end else begin
      slot_ok  = {1'b0, neg_off[14:3]} < 13'(STACK_SLOTS);
      slot_idx = neg_off[SIDX_W+2:3];
    end
  end

  assign slot_bit = SLOT_W'(1) << slot_idx;

  always_comb begin
    reg_nxt    = reg_r;
    slot_nxt   = slot_r;
    status_nxt = ST_OK;
    if (in_ch.action == ACT_LOAD) begin
      reg_nxt  = in_ch.load_regs;
      slot_nxt = in_ch.load_slots;
    end else if (in_ch.opcode != 8'd0) begin
      unique case (cls)
        CLS_ALU, CLS_ALU64: begin
          if ((reg_r & dm) != '0) begin
            if (op == OP_MOV) begin
              reg_nxt = (reg_r & ~dm) | (srcx ? sm : '0);
            end else if (srcx) begin
              reg_nxt = reg_r | sm;
            end
          end
        end
        CLS_LDX: begin
          if ((reg_r & dm) != '0) begin
            reg_nxt = reg_r & ~dm;
            if (in_ch.source_reg == FP_REG) begin
              if (!slot_ok) begin
                status_nxt = ST_FAULT;
              end else begin
                slot_nxt = slot_r | slot_bit;
              end
            end
          end
        end
        CLS_ST, CLS_STX: begin
          if ((reg_r & dm) != '0) begin
            status_nxt = ST_NOTSUPP;
          end else if (in_ch.dest_reg == FP_REG) begin
            if (!slot_ok) begin
              status_nxt = ST_FAULT;
            end else if ((slot_r & slot_bit) != '0) begin
              slot_nxt = slot_r & ~slot_bit;
              if (cls == CLS_STX) begin
                reg_nxt = reg_r | sm;
              end
            end
          end
        end
        CLS_JMP, CLS_JMP32: begin
          if (op == OP_CALL) begin
            if (in_ch.source_reg == PSEUDO_SRC) begin
              status_nxt = ST_NOTSUPP;
            end else begin
              reg_nxt = reg_r & ~REG_W'(1);
              if ((reg_nxt & CALL_REGS) != '0) begin
                status_nxt = ST_FAULT;
              end
            end
          end else if (op == OP_EXIT) begin
            status_nxt = ST_NOTSUPP;
          end else if (srcx && ((reg_r & (dm | sm)) != '0)) begin
            reg_nxt = reg_r | dm | sm;
          end
        end
        CLS_LD: begin
          if ((reg_r & dm) != '0) begin
            reg_nxt = reg_r & ~dm;
            if (mode == MODE_ABS || mode == MODE_IND) begin
              status_nxt = ST_NOTSUPP;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        reg_r       <= reg_nxt;
        slot_r      <= slot_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= status_nxt;
      out_regs_r   <= reg_nxt;
      out_slots_r  <= slot_nxt;
      out_clear_r  <= (reg_nxt == '0) && (slot_nxt == '0);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.regs_out  = out_regs_r;
  assign out_ch.slots_out = out_slots_r;
  assign out_ch.all_clear = out_clear_r;

  // held result always mirrors the tracking state
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_regs_r == reg_r) && (out_slots_r == slot_r))
    else $error("result masks differ from tracking state");

  a_clear_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_clear_r == ((out_regs_r == '0) && (out_slots_r == '0)))
    else $error("all_clear inconsistent with masks");

  a_load_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.action == ACT_LOAD) |=>
      (reg_r == $past(in_ch.load_regs)) && (slot_r == $past(in_ch.load_slots))
      && (out_status_r == ST_OK))
    else $error("load item did not set masks");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(reg_r) && $stable(slot_r))
    else $error("masks changed without an input transfer");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench import pbs_pkg::*; ();

  localparam int SLOT_LIMIT  = STACK_SLOTS_DEF;
  localparam int HOLD_CYCLES = 200;

  localparam logic [3:0] OP_ADD     = 4'h0;
  localparam logic [3:0] OP_JEQ     = 4'h1;
  localparam logic       SRC_K      = 1'b0;
  localparam logic       SRC_X      = 1'b1;
  localparam logic       ACT_STEP   = 1'b1;
  localparam logic [2:0] MODE_IMM   = 3'h0;
  localparam logic [1:0] LD_SIZE_W  = 2'b00;
  localparam logic [1:0] LD_SIZE_DW = 2'b11;

  typedef struct packed {
    logic              action;
    logic [7:0]        opcode;
    logic [3:0]        dst;
    logic [3:0]        src;
    logic signed [15:0] offset;
    logic [REG_W-1:0]  load_regs;
    logic [SLOT_W-1:0] load_slots;
  } insn_t;

  typedef struct packed {
    status_t           status;
    logic [REG_W-1:0]  regs;
    logic [SLOT_W-1:0] slots;
    logic              all_clear;
  } mask_result_t;

  logic clk;
  logic rst_n;

  pbs_in_if  in_ch ();
  pbs_out_if out_ch ();

  precision_backtrack_step dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predicted liveness state
  logic [REG_W-1:0]  live_regs  = '0;
  logic [SLOT_W-1:0] live_slots = '0;
  mask_result_t      expected_masks[$];
  mask_result_t      head;

  int src_gap_pct  = 0;
  int sink_gap_pct = 0;
  int fail_count   = 0;
  bit hold_req     = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // One backward step over live_regs/live_slots, returns the status.
  function automatic status_t step_back(insn_t t);
    logic [3:0]       op;
    logic             srcx;
    logic [REG_W-1:0] dm;
    logic [REG_W-1:0] sm;
    int               q;
    logic             slot_ok;
    op      = t.opcode[7:4];
    srcx    = t.opcode[3];
    dm      = 16'h1 << t.dst;
    sm      = 16'h1 << t.src;
    // truncating division, so offsets -8..6 all land in slot 0
    q       = (-int'(t.offset) - 1) / 8;
    slot_ok = (q >= 0) && (q < SLOT_LIMIT);
    if (t.opcode == 8'h00) return ST_OK;
    case (cls_t'(t.opcode[2:0]))
      CLS_ALU, CLS_ALU64: begin
        if ((live_regs & dm) == '0) return ST_OK;
        if (op == OP_MOV) begin
          live_regs &= ~dm;
          if (srcx) live_regs |= sm;
        end else if (srcx) begin
          live_regs |= sm;
        end
      end
      CLS_LDX: begin
        if ((live_regs & dm) == '0) return ST_OK;
        live_regs &= ~dm;
        if (t.src != FP_REG) return ST_OK;
        if (!slot_ok) return ST_FAULT;
        live_slots[q] = 1'b1;
      end
      CLS_ST, CLS_STX: begin
        if ((live_regs & dm) != '0) return ST_NOTSUPP;
        if (t.dst != FP_REG) return ST_OK;
        if (!slot_ok) return ST_FAULT;
        if (!live_slots[q]) return ST_OK;
        live_slots[q] = 1'b0;
        if (cls_t'(t.opcode[2:0]) == CLS_STX) live_regs |= sm;
      end
      CLS_JMP, CLS_JMP32: begin
        if (op == OP_CALL) begin
          if (t.src == PSEUDO_SRC) return ST_NOTSUPP;
          live_regs[0] = 1'b0;
          // R0 clear sticks even when an argument register is still live
          if ((live_regs & CALL_REGS) != '0) return ST_FAULT;
        end else if (op == OP_EXIT) begin
          return ST_NOTSUPP;
        end else if (srcx && (live_regs & (dm | sm)) != '0) begin
          live_regs |= dm | sm;
        end
      end
      default: begin
        if ((live_regs & dm) == '0) return ST_OK;
        live_regs &= ~dm;
        if (t.opcode[7:5] == MODE_ABS || t.opcode[7:5] == MODE_IND) return ST_NOTSUPP;
      end
    endcase
    return ST_OK;
  endfunction

  function automatic insn_t step_insn(logic [7:0] code, logic [3:0] dst, logic [3:0] src,
                                      logic signed [15:0] off);
    insn_t t;
    t        = '0;
    t.action = ACT_STEP;
    t.opcode = code;
    t.dst    = dst;
    t.src    = src;
    t.offset = off;
    return t;
  endfunction

  function automatic insn_t load_insn(logic [REG_W-1:0] regs, logic [SLOT_W-1:0] slots);
    insn_t t;
    t            = '0;
    t.action     = ACT_LOAD;
    t.load_regs  = regs;
    t.load_slots = slots;
    t.opcode     = 8'($urandom);
    t.dst        = 4'($urandom);
    t.src        = 4'($urandom);
    t.offset     = 16'($urandom);
    return t;
  endfunction

  function automatic logic [3:0] pick_reg();
    int r;
    r = $urandom_range(99);
    if (r < 25) return FP_REG;
    if (r < 60) return 4'($urandom_range(5));
    return 4'($urandom_range(15));
  endfunction

  function automatic insn_t rand_step();
    insn_t      t;
    logic [3:0] op;
    int         r;
    int         v;
    r  = $urandom_range(5);
    op = (r == 0) ? OP_MOV : (r == 1) ? OP_CALL : (r == 2) ? OP_EXIT : 4'($urandom_range(15));
    r  = $urandom_range(9);
    if (r < 6)
      v = -8 * int'($urandom_range(63)) - int'($urandom_range(7));
    else if (r < 8)
      v = int'($urandom_range(620)) - 600;
    else
      v = int'($urandom_range(65535));
    t = step_insn({op, 1'($urandom_range(1)), 3'($urandom_range(7))}, pick_reg(), pick_reg(),
                  16'(v));
    r = $urandom_range(31);
    if (r == 0) t.opcode = 8'h00;
    else if (r == 1) t.opcode = 8'($urandom);
    return t;
  endfunction

  function automatic insn_t rand_load();
    logic [REG_W-1:0]  regs;
    logic [SLOT_W-1:0] slots;
    regs  = 16'($urandom);
    slots = {$urandom, $urandom};
    case ($urandom_range(3))
      0: regs &= 16'($urandom);
      1: slots &= {$urandom, $urandom};
      2: slots = '1;
      default: ;
    endcase
    return load_insn(regs, slots);
  endfunction

  // Offer one item, wait for its transfer, then record the predicted result.
  task automatic send_item(insn_t t);
    mask_result_t want;
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= t.action;
    in_ch.opcode     <= t.opcode;
    in_ch.dest_reg   <= t.dst;
    in_ch.source_reg <= t.src;
    in_ch.offset     <= t.offset;
    in_ch.load_regs  <= t.load_regs;
    in_ch.load_slots <= t.load_slots;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (t.action == ACT_LOAD) begin
      live_regs   = t.load_regs;
      live_slots  = t.load_slots;
      want.status = ST_OK;
    end else begin
      want.status = step_back(t);
    end
    want.regs      = live_regs;
    want.slots     = live_slots;
    want.all_clear = (live_regs == '0) && (live_slots == '0);
    expected_masks.push_back(want);
  endtask

  task automatic test_reset_and_load();
    send_item(step_insn(8'h00, 4'd15, 4'd15, 16'sh7fff));
    send_item(load_insn('1, '1));
    send_item(load_insn('0, '0));
  endtask

  task automatic test_alu();
    send_item(load_insn(16'h0004, '0));
    send_item(step_insn({OP_MOV, SRC_X, CLS_ALU64}, 4'd2, 4'd3, 0));
    send_item(step_insn({OP_ADD, SRC_X, CLS_ALU}, 4'd3, 4'd15, 0));
    send_item(step_insn({OP_ADD, SRC_K, CLS_ALU64}, 4'd3, 4'd9, 0));
    send_item(step_insn({OP_MOV, SRC_K, CLS_ALU}, 4'd15, 4'd0, 0));
    send_item(step_insn({OP_MOV, SRC_X, CLS_ALU}, 4'd0, 4'd7, 0));
  endtask

  task automatic test_frame_loads();
    send_item(load_insn(16'h0c38, '0));
    send_item(step_insn({OP_ADD, SRC_K, CLS_LDX}, 4'd3, FP_REG, -512));
    send_item(step_insn({OP_ADD, SRC_K, CLS_LDX}, 4'd4, FP_REG, 7));
    send_item(step_insn({OP_ADD, SRC_K, CLS_LDX}, 4'd5, FP_REG, -32768));
    send_item(step_insn({OP_ADD, SRC_K, CLS_LDX}, 4'd11, 4'd2, 32767));
  endtask

  task automatic test_frame_stores();
    send_item(step_insn({OP_ADD, SRC_X, CLS_STX}, FP_REG, 4'd1, -8));
    send_item(load_insn(16'h0001, 64'h8000_0000_0000_0001));
    send_item(step_insn({OP_ADD, SRC_K, CLS_ST}, FP_REG, 4'd0, 0));
    send_item(step_insn({OP_ADD, SRC_X, CLS_STX}, FP_REG, 4'd6, -505));
    send_item(step_insn({OP_ADD, SRC_X, CLS_STX}, FP_REG, 4'd7, -16));
    send_item(step_insn({OP_ADD, SRC_K, CLS_ST}, FP_REG, 4'd0, -513));
  endtask

  task automatic test_jumps();
    send_item(step_insn({OP_CALL, SRC_K, CLS_JMP}, 4'd0, PSEUDO_SRC, 0));
    send_item(step_insn({OP_JEQ, SRC_X, CLS_JMP32}, 4'd6, 4'd9, 0));
    send_item(step_insn({OP_EXIT, SRC_K, CLS_JMP}, 4'd0, 4'd0, 0));
    send_item(step_insn({OP_CALL, SRC_K, CLS_JMP}, 4'd0, 4'd0, 0));
    send_item(load_insn(16'h0005, '0));
    send_item(step_insn({OP_CALL, SRC_K, CLS_JMP32}, 4'd0, 4'd0, 0));
  endtask

  task automatic test_ld_modes();
    send_item(step_insn({MODE_IMM, LD_SIZE_DW, CLS_LD}, 4'd2, 4'd0, 0));
    send_item(load_insn(16'h0006, '0));
    send_item(step_insn({MODE_ABS, LD_SIZE_W, CLS_LD}, 4'd1, 4'd0, 0));
    send_item(step_insn({MODE_IND, LD_SIZE_W, CLS_LD}, 4'd2, 4'd3, 0));
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    src_gap_pct = 0;
    hold_req    = 1'b1;
    send_item(rand_load());
    repeat (40) send_item(rand_step());
  endtask

  // Load-then-walk sequences with random content.
  task automatic test_random_walk(int count);
    for (int k = 0; k < count; k++) begin
      if (k == 0 || $urandom_range(11) == 0) send_item(rand_load());
      else send_item(rand_step());
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_masks.size() == 0) begin
        $error("result transfer with nothing pending");
        fail_count++;
      end else begin
        head = expected_masks.pop_front();
        if (out_ch.status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.regs_out !== head.regs) begin
          $error("regs_out: expected %h, got %h", head.regs, out_ch.regs_out);
          fail_count++;
        end
        if (out_ch.slots_out !== head.slots) begin
          $error("slots_out: expected %h, got %h", head.slots, out_ch.slots_out);
          fail_count++;
        end
        if (out_ch.all_clear !== head.all_clear) begin
          $error("all_clear: expected %b, got %b", head.all_clear, out_ch.all_clear);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_LOAD;
    in_ch.opcode     <= '0;
    in_ch.dest_reg   <= '0;
    in_ch.source_reg <= '0;
    in_ch.offset     <= '0;
    in_ch.load_regs  <= '0;
    in_ch.load_slots <= '0;
    src_gap_pct  = 6;
    sink_gap_pct = 76;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_and_load();
    test_alu();
    test_frame_loads();
    test_frame_stores();
    test_jumps();
    test_ld_modes();
    test_backpressure();

    src_gap_pct  = 6;
    sink_gap_pct = 76;
    test_random_walk(600);
    src_gap_pct  = 76;
    sink_gap_pct = 6;
    test_random_walk(600);
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    test_random_walk(600);

    in_ch.valid <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
